// ===== src/trapezoidal_state_variable_filter_core_assert.svh =====
// Assertion macros shared by the filter checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef TRAPEZOIDAL_STATE_VARIABLE_FILTER_CORE_ASSERT_SVH
`define TRAPEZOIDAL_STATE_VARIABLE_FILTER_CORE_ASSERT_SVH

// Same-cycle implication
`define SVF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("svf check failed");

// Next-cycle implication
`define SVF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("svf check failed");

`endif

// ===== src/svf_pkg.sv =====
// Package for the trapezoidal state-variable filter: constants, tables,
// divider request/response types. No dependencies.
`default_nettype none
package svf_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 24;
  localparam int unsigned STATE_WIDTH_DEF  = 32;

  localparam logic [17:0] RATE_RESET = 18'd48000;
  localparam logic [17:0] RATE_MIN   = 18'd8000;
  localparam logic [17:0] RATE_MAX   = 18'd192000;
  localparam logic [16:0] RES_ONE    = 17'd65536;
  localparam logic [17:0] K_MAX      = 18'd131072;

  localparam logic [31:0] ONE_Q30     = 32'd1073741824;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Restoring divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = 64;

  // 2^32, base of the series reciprocals
  localparam logic [63:0] RCP_ONE = 64'h0000_0001_0000_0000;

  // Series divisors, Horner order
  function automatic logic [7:0] sin_div(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'd110;
      3'd1:    v = 8'd72;
      3'd2:    v = 8'd42;
      3'd3:    v = 8'd20;
      default: v = 8'd6;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] cos_div(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'd132;
      3'd1:    v = 8'd90;
      3'd2:    v = 8'd56;
      3'd3:    v = 8'd30;
      default: v = 8'd12;
    endcase
    return v;
  endfunction

  // floor(2^32 / divisor): the estimate it gives is low by at most one
  function automatic logic [31:0] sin_rcp(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'(RCP_ONE / 64'd110);
      3'd1:    v = 32'(RCP_ONE / 64'd72);
      3'd2:    v = 32'(RCP_ONE / 64'd42);
      3'd3:    v = 32'(RCP_ONE / 64'd20);
      default: v = 32'(RCP_ONE / 64'd6);
    endcase
    return v;
  endfunction

  function automatic logic [31:0] cos_rcp(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'(RCP_ONE / 64'd132);
      3'd1:    v = 32'(RCP_ONE / 64'd90);
      3'd2:    v = 32'(RCP_ONE / 64'd56);
      3'd3:    v = 32'(RCP_ONE / 64'd30);
      default: v = 32'(RCP_ONE / 64'd12);
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== src/svf_in_if.sv =====
// Input channel of the filter: one sample beat with cutoff and resonance.
// Stand-alone, no dependencies.
`default_nettype none
interface svf_in_if #(
  parameter int unsigned SW = 24
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] sample_in;
  logic        [16:0]   cutoff_hz;
  logic        [16:0]   resonance;

  modport source (output valid, output sample_in, output cutoff_hz, output resonance,
                  input ready);
  modport sink   (input valid, input sample_in, input cutoff_hz, input resonance,
                  output ready);
endinterface
`default_nettype wire

// ===== src/svf_out_if.sv =====
// Output channel of the filter: the six responses of one sample as one beat.
// Stand-alone, no dependencies.
`default_nettype none
interface svf_out_if #(
  parameter int unsigned SW = 24
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] low_out;
  logic signed [SW-1:0] band_out;
  logic signed [SW-1:0] high_out;
  logic signed [SW-1:0] notch_out;
  logic signed [SW-1:0] peak_out;
  logic signed [SW-1:0] allpass_out;

  modport source (output valid, output low_out, output band_out, output high_out,
                  output notch_out, output peak_out, output allpass_out, input ready);
  modport sink   (input valid, input low_out, input band_out, input high_out,
                  input notch_out, input peak_out, input allpass_out, output ready);
endinterface
`default_nettype wire

// ===== src/svf_div.sv =====
// Iterative unsigned divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// Uses svf_pkg for the request/response types.
`default_nettype none
module svf_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire svf_pkg::div_req_t req_i,
  output svf_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned CW = $clog2(svf_pkg::DIV_STEPS + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [63:0]   dvd_q, dvd_d;
  logic [31:0]   rem_q, rem_d;
  logic [31:0]   dsr_q, dsr_d;

  logic [32:0]   rem_sh;
  logic [32:0]   rem_sub;
  logic          ge;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_q, dvd_q[63]};
    ge      = rem_sh >= {1'b0, dsr_q};
    rem_sub = rem_sh - {1'b0, dsr_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(svf_pkg::DIV_STEPS);
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[31:0] : rem_sh[31:0];
      dvd_d = {dvd_q[62:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule
`default_nettype wire

// ===== src/trapezoidal_state_variable_filter_core.sv =====
// Channel  | dir | payload                                    | handshake
// in_i     | in  | sample_in, cutoff_hz, resonance            | valid/ready
// out_o    | out | low, band, high, notch, peak, allpass      | valid/ready
// cfg      | in  | cfg_wdata_i (sample rate, Hz)              | cfg_we_i, no wait
//
// From accept to the next ready, one sample takes four runs of the shared 64-step divider
// (three when the cutoff is clamped to half rate) and a sequence of steps on the shared
// 32x32 multiplier, ten series terms among them. in_i is ready only while idle.
// The result sits in an output register; a new sample is taken while it waits,
// but the next result is held back until the previous beat has gone.
// Reset clears both integrators and sets the sample rate to 48000 Hz.
// Depends on svf_pkg, svf_in_if, svf_out_if and svf_div.
`default_nettype none
module trapezoidal_state_variable_filter_core #(
  parameter int unsigned SAMPLE_WIDTH = svf_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned STATE_WIDTH  = svf_pkg::STATE_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [17:0] cfg_wdata_i,
  svf_in_if.sink           in_i,
  svf_out_if.source        out_o
);

  // Shift between sample and state formats
  localparam int SH  = int'(STATE_WIDTH) - int'(SAMPLE_WIDTH) - 3;
  localparam int SHL = (SH >= 0) ? SH : 0;
  localparam int SHR = (SH < 0) ? -SH : 0;

  localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] OUT_MIN = -OUT_MAX - 64'sd1;
  localparam logic signed [63:0] ST_MAX  = (64'sd1 <<< (STATE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] ST_MIN  = -ST_MAX - 64'sd1;

  // Sequencer states
  localparam logic [5:0] S_IDLE = 6'd0;
  localparam logic [5:0] S_THM  = 6'd1;
  localparam logic [5:0] S_THD  = 6'd2;
  localparam logic [5:0] S_THW  = 6'd3;
  localparam logic [5:0] S_TH2  = 6'd4;
  localparam logic [5:0] S_TT   = 6'd5;
  localparam logic [5:0] S_LM   = 6'd6;
  localparam logic [5:0] S_LD   = 6'd7;
  localparam logic [5:0] S_LW   = 6'd8;
  localparam logic [5:0] S_SM   = 6'd9;
  localparam logic [5:0] S_SS   = 6'd10;
  localparam logic [5:0] S_CM   = 6'd11;
  localparam logic [5:0] S_CQ   = 6'd12;
  localparam logic [5:0] S_MC2  = 6'd13;
  localparam logic [5:0] S_MS2  = 6'd14;
  localparam logic [5:0] S_MSC  = 6'd15;
  localparam logic [5:0] S_MSK  = 6'd16;
  localparam logic [5:0] S_MK   = 6'd17;
  localparam logic [5:0] S_DD   = 6'd18;
  localparam logic [5:0] S_A1S  = 6'd19;
  localparam logic [5:0] S_A1W  = 6'd20;
  localparam logic [5:0] S_A2S  = 6'd21;
  localparam logic [5:0] S_A2W  = 6'd22;
  localparam logic [5:0] S_A3S  = 6'd23;
  localparam logic [5:0] S_A3W  = 6'd24;
  localparam logic [5:0] S_V0   = 6'd25;
  localparam logic [5:0] S_V1A  = 6'd26;
  localparam logic [5:0] S_V1B  = 6'd27;
  localparam logic [5:0] S_V2A  = 6'd28;
  localparam logic [5:0] S_V2B  = 6'd29;
  localparam logic [5:0] S_OUT  = 6'd30;
  localparam logic [5:0] S_MCL  = 6'd31;
  localparam logic [5:0] S_MCH  = 6'd32;
  localparam logic [5:0] S_MCR  = 6'd33;
  localparam logic [5:0] S_LQ   = 6'd34;

  localparam logic [2:0] LAST_TERM = 3'd4;

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_out(input logic signed [63:0] r);
    logic signed [63:0] v;
    v = (r >>> SHL) <<< SHR;
    if (v > OUT_MAX) v = OUT_MAX;
    else if (v < OUT_MIN) v = OUT_MIN;
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  function automatic logic signed [STATE_WIDTH-1:0] sat_state(input logic signed [63:0] r);
    logic signed [63:0] v;
    v = r;
    if (v > ST_MAX) v = ST_MAX;
    else if (v < ST_MIN) v = ST_MIN;
    return v[STATE_WIDTH-1:0];
  endfunction

  // Control registers
  logic [5:0]  state_q, state_d;
  logic [5:0]  ret_q, ret_d;
  logic [17:0] rate_q;
  logic [2:0]  i_q, i_d;
  logic        cos_q, cos_d;
  logic        mc16_q, mc16_d;
  logic        ov_q, ov_d;
  logic signed [STATE_WIDTH-1:0] band_q, band_d;
  logic signed [STATE_WIDTH-1:0] low_q, low_d;

  // Working registers
  logic [16:0] fc_q, fc_d;
  logic [17:0] k_q, k_d;
  logic [30:0] th_q, th_d;
  logic [31:0] t_q, t_d;
  logic [30:0] p_q, p_d;
  logic [31:0] x_q, x_d, qe_q, qe_d;
  logic [31:0] s_q, s_d, c_q, c_d;
  logic [31:0] c2_q, c2_d, s2_q, s2_d, sc_q, sc_d;
  logic [31:0] d_q, d_d;
  logic [31:0] a1_q, a1_d, a2_q, a2_d, a3_q, a3_d;
  logic [31:0] mcc_q, mcc_d;
  logic [63:0] prod_q, prod_d, lo_q, lo_d;
  logic signed [63:0] v0_q, v0_d, v3_q, v3_d, v1_q, v1_d, v2_q, v2_d, acc_q, acc_d;
  logic signed [63:0] mca_q, mca_d, mcr_q, mcr_d;

  // Output register
  logic signed [SAMPLE_WIDTH-1:0] lo_out_q, bd_out_q, hi_out_q;
  logic signed [SAMPLE_WIDTH-1:0] nt_out_q, pk_out_q, ap_out_q;
  logic signed [SAMPLE_WIDTH-1:0] lo_out_d, bd_out_d, hi_out_d;
  logic signed [SAMPLE_WIDTH-1:0] nt_out_d, pk_out_d, ap_out_d;

  logic [31:0] mul_a, mul_b;
  logic [17:0] rate_c;
  logic [16:0] res_c;
  logic [63:0] mag, r_sum;
  logic [32:0] q_cos;
  logic [63:0] d_sum;
  logic [7:0]  ser_div;
  logic [31:0] ser_rcp;
  logic [32:0] ser_rem;
  logic [31:0] ser_q;
  logic signed [63:0] low_x, band_x, hi_v, kb_v;
  logic        in_acc, out_busy;

  svf_pkg::div_req_t div_req;
  svf_pkg::div_rsp_t div_rsp;

  svf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_busy   = ov_q && !out_o.ready;
  assign low_x      = 64'(low_q);
  assign band_x     = 64'(band_q);

  // Clamped rate and resonance
  always_comb begin
    rate_c = rate_q;
    if (rate_c < svf_pkg::RATE_MIN) rate_c = svf_pkg::RATE_MIN;
    if (rate_c > svf_pkg::RATE_MAX) rate_c = svf_pkg::RATE_MAX;
    res_c = in_i.resonance;
    if (res_c > svf_pkg::RES_ONE) res_c = svf_pkg::RES_ONE;
  end

  // Series term divisor and its reciprocal
  always_comb begin
    ser_div = cos_q ? svf_pkg::cos_div(i_q) : svf_pkg::sin_div(i_q);
    ser_rcp = cos_q ? svf_pkg::cos_rcp(i_q) : svf_pkg::sin_rcp(i_q);
    // remainder of the estimate is below twice the divisor: one correction
    ser_rem = {1'b0, x_q} - prod_q[32:0];
    ser_q   = qe_q + 32'(ser_rem >= {25'd0, ser_div});
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_THM:   begin mul_a = 32'(fc_q);        mul_b = svf_pkg::PI_Q30; end
      S_TH2:   begin mul_a = 32'(th_q);        mul_b = 32'(th_q);       end
      S_LM:    begin mul_a = t_q;              mul_b = 32'(p_q);        end
      S_LD:    begin mul_a = prod_q[61:30];    mul_b = ser_rcp;         end
      S_LQ:    begin mul_a = prod_q[63:32];    mul_b = 32'(ser_div);    end
      S_SM:    begin mul_a = 32'(th_q);        mul_b = 32'(p_q);        end
      S_CM:    begin mul_a = t_q;              mul_b = 32'(p_q);        end
      S_MC2:   begin mul_a = c_q;              mul_b = c_q;             end
      S_MS2:   begin mul_a = s_q;              mul_b = s_q;             end
      S_MSC:   begin mul_a = s_q;              mul_b = c_q;             end
      S_MK:    begin mul_a = sc_q;             mul_b = 32'(k_q);        end
      S_MCL:   begin mul_a = mag[31:0];        mul_b = mcc_q;           end
      S_MCH:   begin mul_a = mag[63:32];       mul_b = mcc_q;           end
      default: begin mul_a = '0;               mul_b = '0;              end
    endcase
    prod_d = 64'(mul_a) * 64'(mul_b);
  end

  // Shared divider request select
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = 32'd1;
    unique case (state_q)
      S_THD: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q;
        div_req.divisor  = 32'(rate_c);
      end
      S_A1S: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(c2_q) << 30;
        div_req.divisor  = d_q;
      end
      S_A2S: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(sc_q) << 30;
        div_req.divisor  = d_q;
      end
      S_A3S: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(s2_q) << 30;
        div_req.divisor  = d_q;
      end
      default: begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = 32'd1;
      end
    endcase
  end

  // Scaled product helpers: magnitude, cos half-term, partial sums
  always_comb begin
    mag   = mca_q[63] ? (~mca_q + 64'd1) : mca_q;
    r_sum = (mc16_q ? (prod_q << 16) : (prod_q << 2)) + lo_q;
    q_cos = prod_q[63:31];
    d_sum = 64'(c2_q) + 64'(s2_q) + (prod_q >> 16);
    kb_v  = mcr_q;
    hi_v  = v0_q - kb_v - v2_q;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    i_d     = i_q;
    cos_d   = cos_q;
    mc16_d  = mc16_q;
    ov_d    = ov_q;
    band_d  = band_q;
    low_d   = low_q;
    fc_d    = fc_q;
    k_d     = k_q;
    th_d    = th_q;
    t_d     = t_q;
    p_d     = p_q;
    x_d     = x_q;
    qe_d    = qe_q;
    s_d     = s_q;
    c_d     = c_q;
    c2_d    = c2_q;
    s2_d    = s2_q;
    sc_d    = sc_q;
    d_d     = d_q;
    a1_d    = a1_q;
    a2_d    = a2_q;
    a3_d    = a3_q;
    mcc_d   = mcc_q;
    lo_d    = lo_q;
    v0_d    = v0_q;
    v3_d    = v3_q;
    v1_d    = v1_q;
    v2_d    = v2_q;
    acc_d   = acc_q;
    mca_d   = mca_q;
    mcr_d   = mcr_q;
    lo_out_d = lo_out_q;
    bd_out_d = bd_out_q;
    hi_out_d = hi_out_q;
    nt_out_d = nt_out_q;
    pk_out_d = pk_out_q;
    ap_out_d = ap_out_q;

    if (ov_q && out_o.ready) ov_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          fc_d = in_i.cutoff_hz;
          k_d  = svf_pkg::K_MAX - {res_c, 1'b0};
          v0_d = (64'(in_i.sample_in) <<< SHL) >>> SHR;
          if ({in_i.cutoff_hz, 1'b0} > rate_c) begin
            th_d    = svf_pkg::HALF_PI_Q30;
            state_d = S_TH2;
          end else begin
            state_d = S_THM;
          end
        end
      end
      S_THM: state_d = S_THD;
      S_THD: state_d = S_THW;
      S_THW: begin
        if (div_rsp.done) begin
          th_d    = div_rsp.quotient[30:0];
          state_d = S_TH2;
        end
      end
      S_TH2: state_d = S_TT;
      S_TT: begin
        t_d     = prod_q[61:30];
        p_d     = svf_pkg::ONE_Q30[30:0];
        i_d     = '0;
        cos_d   = 1'b0;
        state_d = S_LM;
      end
      S_LM: state_d = S_LD;
      // Series term by reciprocal: estimate, back-multiply, correct
      S_LD: begin
        x_d     = prod_q[61:30];
        state_d = S_LQ;
      end
      S_LQ: begin
        qe_d    = prod_q[63:32];
        state_d = S_LW;
      end
      S_LW: begin
        p_d = 31'(svf_pkg::ONE_Q30 - ser_q);
        if (i_q == LAST_TERM) begin
          state_d = cos_q ? S_CM : S_SM;
        end else begin
          i_d     = i_q + 3'd1;
          state_d = S_LM;
        end
      end
      S_SM: state_d = S_SS;
      S_SS: begin
        s_d     = prod_q[61:30];
        cos_d   = 1'b1;
        p_d     = svf_pkg::ONE_Q30[30:0];
        i_d     = '0;
        state_d = S_LM;
      end
      S_CM: state_d = S_CQ;
      S_CQ: begin
        // cos floors at zero
        c_d     = (q_cos >= 33'(svf_pkg::ONE_Q30)) ? '0
                  : 32'(33'(svf_pkg::ONE_Q30) - q_cos);
        state_d = S_MC2;
      end
      S_MC2: state_d = S_MS2;
      S_MS2: begin
        c2_d    = prod_q[61:30];
        state_d = S_MSC;
      end
      S_MSC: begin
        s2_d    = prod_q[61:30];
        state_d = S_MSK;
      end
      S_MSK: begin
        sc_d    = prod_q[61:30];
        state_d = S_MK;
      end
      S_MK: state_d = S_DD;
      S_DD: begin
        d_d     = (d_sum[31:0] == 32'd0) ? 32'd1 : d_sum[31:0];
        state_d = S_A1S;
      end
      S_A1S: state_d = S_A1W;
      S_A1W: begin
        if (div_rsp.done) begin
          a1_d    = div_rsp.quotient[31:0];
          state_d = S_A2S;
        end
      end
      S_A2S: state_d = S_A2W;
      S_A2W: begin
        if (div_rsp.done) begin
          a2_d    = div_rsp.quotient[31:0];
          state_d = S_A3S;
        end
      end
      S_A3S: state_d = S_A3W;
      S_A3W: begin
        if (div_rsp.done) begin
          a3_d    = div_rsp.quotient[31:0];
          state_d = S_V0;
        end
      end
      // Filter update as a chain of scaled products
      S_V0: begin
        v3_d    = v0_q - low_x;
        mca_d   = band_x;
        mcc_d   = a1_q;
        mc16_d  = 1'b0;
        ret_d   = S_V1A;
        state_d = S_MCL;
      end
      S_V1A: begin
        acc_d   = mcr_q;
        mca_d   = v3_q;
        mcc_d   = a2_q;
        ret_d   = S_V1B;
        state_d = S_MCL;
      end
      S_V1B: begin
        v1_d    = acc_q + mcr_q;
        mca_d   = band_x;
        mcc_d   = a2_q;
        ret_d   = S_V2A;
        state_d = S_MCL;
      end
      S_V2A: begin
        acc_d   = low_x + mcr_q;
        mca_d   = v3_q;
        mcc_d   = a3_q;
        ret_d   = S_V2B;
        state_d = S_MCL;
      end
      S_V2B: begin
        v2_d    = acc_q + mcr_q;
        mca_d   = v1_q;
        mcc_d   = 32'(k_q);
        mc16_d  = 1'b1;
        ret_d   = S_OUT;
        state_d = S_MCL;
      end
      S_OUT: begin
        if (!out_busy) begin
          lo_out_d = sat_out(v2_q);
          bd_out_d = sat_out(v1_q);
          hi_out_d = sat_out(hi_v);
          nt_out_d = sat_out(v2_q + hi_v);
          pk_out_d = sat_out(v2_q - hi_v);
          ap_out_d = sat_out(v2_q + hi_v - kb_v);
          ov_d     = 1'b1;
          band_d   = sat_state((v1_q <<< 1) - band_x);
          low_d    = sat_state((v2_q <<< 1) - low_x);
          state_d  = S_IDLE;
        end
      end
      // Signed value times coefficient, truncated toward zero
      S_MCL: state_d = S_MCH;
      S_MCH: begin
        lo_d    = mc16_q ? (prod_q >> 16) : (prod_q >> 30);
        state_d = S_MCR;
      end
      S_MCR: begin
        mcr_d   = mca_q[63] ? -$signed(r_sum) : $signed(r_sum);
        state_d = ret_q;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      rate_q  <= svf_pkg::RATE_RESET;
      i_q     <= '0;
      cos_q   <= 1'b0;
      mc16_q  <= 1'b0;
      ov_q    <= 1'b0;
      band_q  <= '0;
      low_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (cfg_we_i) rate_q <= cfg_wdata_i;
      i_q     <= i_d;
      cos_q   <= cos_d;
      mc16_q  <= mc16_d;
      ov_q    <= ov_d;
      band_q  <= band_d;
      low_q   <= low_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    fc_q     <= fc_d;
    k_q      <= k_d;
    th_q     <= th_d;
    t_q      <= t_d;
    p_q      <= p_d;
    x_q      <= x_d;
    qe_q     <= qe_d;
    s_q      <= s_d;
    c_q      <= c_d;
    c2_q     <= c2_d;
    s2_q     <= s2_d;
    sc_q     <= sc_d;
    d_q      <= d_d;
    a1_q     <= a1_d;
    a2_q     <= a2_d;
    a3_q     <= a3_d;
    mcc_q    <= mcc_d;
    lo_q     <= lo_d;
    v0_q     <= v0_d;
    v3_q     <= v3_d;
    v1_q     <= v1_d;
    v2_q     <= v2_d;
    acc_q    <= acc_d;
    mca_q    <= mca_d;
    mcr_q    <= mcr_d;
    lo_out_q <= lo_out_d;
    bd_out_q <= bd_out_d;
    hi_out_q <= hi_out_d;
    nt_out_q <= nt_out_d;
    pk_out_q <= pk_out_d;
    ap_out_q <= ap_out_d;
  end

  assign out_o.valid       = ov_q;
  assign out_o.low_out     = lo_out_q;
  assign out_o.band_out    = bd_out_q;
  assign out_o.high_out    = hi_out_q;
  assign out_o.notch_out   = nt_out_q;
  assign out_o.peak_out    = pk_out_q;
  assign out_o.allpass_out = ap_out_q;

endmodule
`default_nettype wire

// ===== src/svf_checker.sv =====
// Port-level checks for the filter core, bound to the top level.
// Depends on the assertion macro header.
`default_nettype none
`include "trapezoidal_state_variable_filter_core_assert.svh"
module svf_checker #(
  parameter int unsigned SW = 24
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_i,
  input wire logic                 out_valid_i,
  input wire logic                 out_ready_i,
  input wire logic signed [SW-1:0] low_out_i
);

  // A beat in starts a long computation: no ready and no fresh result next cycle
  `SVF_ASSERT_NXT(a_busy_after_beat, in_valid_i && in_ready_i, !in_ready_i)
  `SVF_ASSERT_NXT(a_no_instant_result, in_valid_i && in_ready_i, !$rose(out_valid_i))
  // Stalled result is held
  `SVF_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `SVF_ASSERT_NXT(a_out_stable, out_valid_i && !out_ready_i, $stable(low_out_i))

endmodule

bind trapezoidal_state_variable_filter_core svf_checker #(.SW(SAMPLE_WIDTH)) u_svf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .low_out_i   (out_o.low_out)
);
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for trapezoidal_state_variable_filter_core: random and
// directed sample beats, predicted responses compared against each output beat.
// Depends on svf_pkg, svf_in_if, svf_out_if and the filter core.
module tb;

  localparam int SW    = 24;
  localparam int TW    = 32;
  localparam int SHIFT = (TW - 4) - (SW - 1);

  typedef struct packed {
    logic signed [SW-1:0] smp;
    logic        [16:0]   fc;
    logic        [16:0]   res;
  } smp_beat_t;

  typedef struct packed {
    logic signed [SW-1:0] lo;
    logic signed [SW-1:0] bd;
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] nt;
    logic signed [SW-1:0] pk;
    logic signed [SW-1:0] ap;
  } resp_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [17:0] cfg_wdata_i;

  svf_in_if  #(.SW(SW)) in_ch ();
  svf_out_if #(.SW(SW)) out_ch ();

  trapezoidal_state_variable_filter_core #(
    .SAMPLE_WIDTH(SW),
    .STATE_WIDTH (TW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source)
  );

  smp_beat_t  pending_q[$];
  resp_beat_t resp_q[$];
  int         n_err;
  int         src_idle_pct;
  int         snk_idle_pct;
  logic       src_hold;
  logic       in_taken;

  // Filter state as the bench sees it
  logic [17:0]    rate_reg;
  longint         band_st;
  longint         low_st;

  // Clock and watchdog timeout
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("tb: done, errors");
    $finish;
  end

  function automatic longint sat(longint v, int w);
    longint hi_l;
    longint lo_l;
    hi_l = (longint'(1) <<< (w - 1)) - 1;
    lo_l = -hi_l - 1;
    return v > hi_l ? hi_l : (v < lo_l ? lo_l : v);
  endfunction

  // (a * c) >> sh, truncated toward zero
  function automatic longint coef_mul(longint a, logic [63:0] c, int sh);
    logic [127:0] m;
    logic [127:0] p;
    m = a < 0 ? 128'(-a) : 128'(a);
    p = (m * {64'd0, c}) >> sh;
    return a < 0 ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  // Advance the filter by one sample and return its six responses
  function automatic resp_beat_t svf_filter(smp_beat_t b);
    logic [63:0] fs, fc, res, th, t, p, q, s, c, c2, s2, sc, k, d, a1, a2, a3;
    longint v0, v3, v1, v2, kb, r[6];
    logic [SW-1:0] o[6];
    resp_beat_t rb;
    fs  = rate_reg;
    fc  = b.fc;
    res = b.res;
    if (fs < svf_pkg::RATE_MIN) fs = svf_pkg::RATE_MIN;
    if (fs > svf_pkg::RATE_MAX) fs = svf_pkg::RATE_MAX;
    if (res > svf_pkg::RES_ONE) res = svf_pkg::RES_ONE;
    k  = 2 * svf_pkg::RES_ONE - 2 * res;
    th = (2 * fc > fs) ? 64'(svf_pkg::HALF_PI_Q30) : (fc * svf_pkg::PI_Q30) / fs;
    t = (th * th) >> 30;
    p = svf_pkg::ONE_Q30;
    for (int i = 0; i < 5; i++)
      p = svf_pkg::ONE_Q30 - ((t * p) >> 30) / svf_pkg::sin_div(3'(i));
    s = (th * p) >> 30;
    p = svf_pkg::ONE_Q30;
    for (int i = 0; i < 5; i++)
      p = svf_pkg::ONE_Q30 - ((t * p) >> 30) / svf_pkg::cos_div(3'(i));
    q = ((t * p) >> 30) / 2;
    c = q >= svf_pkg::ONE_Q30 ? 64'd0 : svf_pkg::ONE_Q30 - q;
    c2 = (c * c) >> 30;
    s2 = (s * s) >> 30;
    sc = (s * c) >> 30;
    d  = c2 + s2 + ((sc * k) >> 16);
    if (d == 0) d = 1;
    a1 = (c2 << 30) / d;
    a2 = (sc << 30) / d;
    a3 = (s2 << 30) / d;
    v0 = longint'(b.smp) <<< SHIFT;
    v3 = v0 - low_st;
    v1 = coef_mul(band_st, a1, 30) + coef_mul(v3, a2, 30);
    v2 = low_st + coef_mul(band_st, a2, 30) + coef_mul(v3, a3, 30);
    kb = coef_mul(v1, k, 16);
    r[0] = v2;
    r[1] = v1;
    r[2] = v0 - kb - v2;
    r[3] = r[0] + r[2];
    r[4] = r[0] - r[2];
    r[5] = r[0] + r[2] - kb;
    for (int i = 0; i < 6; i++) o[i] = SW'(sat(r[i] >>> SHIFT, SW));
    band_st = sat(2 * v1 - band_st, TW);
    low_st  = sat(2 * v2 - low_st, TW);
    rb = '{o[0], o[1], o[2], o[3], o[4], o[5]};
    return rb;
  endfunction

  // Driver: payload and valid change on the falling edge
  always @(negedge clk_i) begin
    if (!(in_ch.valid && !in_taken)) begin
      if (pending_q.size() > 0 && !src_hold && $urandom_range(99) >= src_idle_pct) begin
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= pending_q[0].smp;
        in_ch.cutoff_hz <= pending_q[0].fc;
        in_ch.resonance <= pending_q[0].res;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= $urandom_range(99) >= snk_idle_pct;
  end

  // Monitor: input acceptance and output beat check on the rising edge
  always @(posedge clk_i) begin
    resp_beat_t got;
    resp_beat_t want;
    in_taken <= 1'b0;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      want = svf_filter(pending_q[0]);
      resp_q.insert(resp_q.size(), want);
      void'(pending_q.pop_front());
      in_taken <= 1'b1;
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.low_out, out_ch.band_out, out_ch.high_out,
              out_ch.notch_out, out_ch.peak_out, out_ch.allpass_out};
      if (resp_q.size() == 0) begin
        n_err++;
        $display("%0t unexpected beat: expected none, actual %h", $time, got);
      end else begin
        want = resp_q.pop_front();
        if (got.lo !== want.lo) begin
          n_err++; $display("%0t low: expected %0d, actual %0d", $time, want.lo, got.lo);
        end
        if (got.bd !== want.bd) begin
          n_err++; $display("%0t band: expected %0d, actual %0d", $time, want.bd, got.bd);
        end
        if (got.hi !== want.hi) begin
          n_err++; $display("%0t high: expected %0d, actual %0d", $time, want.hi, got.hi);
        end
        if (got.nt !== want.nt) begin
          n_err++; $display("%0t notch: expected %0d, actual %0d", $time, want.nt, got.nt);
        end
        if (got.pk !== want.pk) begin
          n_err++; $display("%0t peak: expected %0d, actual %0d", $time, want.pk, got.pk);
        end
        if (got.ap !== want.ap) begin
          n_err++; $display("%0t allpass: expected %0d, actual %0d", $time, want.ap, got.ap);
        end
      end
    end
  end

  task automatic push_beat(logic signed [SW-1:0] smp, logic [16:0] fc, logic [16:0] res);
    smp_beat_t b;
    b = '{smp, fc, res};
    pending_q.insert(pending_q.size(), b);
  endtask

  // Wait until every queued beat has gone through, plus a margin
  task automatic drain();
    while (pending_q.size() > 0 || resp_q.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_rate(logic [17:0] r);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    rate_reg     = r;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly musical settings, some full-range noise
  task automatic push_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8)
        push_beat(SW'($urandom_range(2 * 2000000) - 2000000),
                  17'($urandom_range(24000, 20)), 17'($urandom_range(65000)));
      else
        push_beat(SW'($urandom), 17'($urandom), 17'($urandom));
    end
  endtask

  // Stimulus
  initial begin
    logic [17:0] rates[6];
    rates = '{18'd48000, 18'd8000, 18'd192000, 18'd0, 18'h3FFFF, 18'd44100};
    n_err        = 0;
    src_idle_pct = 22;
    snk_idle_pct = 71;
    src_hold     = 1'b0;
    in_taken     = 1'b0;
    rate_reg     = svf_pkg::RATE_RESET;
    band_st      = 0;
    low_st       = 0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    in_ch.cutoff_hz = '0;
    in_ch.resonance = '0;
    out_ch.ready    = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, clamped cutoff, resonance above one, saturation
    push_beat(24'sh7FFFFF, 17'd1000, 17'd0);
    push_beat(-24'sh800000, 17'd1000, 17'd0);
    push_beat(24'sh7FFFFF, 17'd0, 17'd0);
    push_beat(24'sh7FFFFF, 17'd24000, 17'd32768);
    push_beat(-24'sh800000, 17'd24001, 17'd32768);
    push_beat(24'sh7FFFFF, 17'd96000, 17'd65536);
    push_beat(24'sh7FFFFF, 17'h1FFFF, 17'h1FFFF);
    push_beat(24'sd0, 17'd12000, 17'd65536);
    push_beat(24'sh7FFFFF, 17'd12000, 17'd65536);
    push_beat(-24'sh800000, 17'd12000, 17'd65536);
    push_beat(24'sh7FFFFF, 17'd12000, 17'd65535);
    push_beat(-24'sh800000, 17'd23999, 17'd0);
    push_beat(24'sh555555, 17'h0AAAA, 17'h15555);
    push_beat(-24'sh555556, 17'h15555, 17'h0AAAA);
    push_beat(24'sd1, 17'd1, 17'd1);
    push_beat(-24'sd1, 17'd20, 17'd100);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_rate(rates[ph]);
      src_idle_pct = ph < 2 ? 22 : (ph < 4 ? 71 : 0);
      snk_idle_pct = ph < 2 ? 71 : (ph < 4 ? 22 : 0);
      push_random(120);
      // Hold the sender until every accepted beat has come out and valid is low
      if (ph == 1) begin
        src_hold = 1'b1;
        while (resp_q.size() > 0 || in_ch.valid) @(posedge clk_i);
        src_hold = 1'b0;
      end
      push_random(120);
      drain();
    end
    write_rate(18'd96000);
    push_random(10);
    drain();

    if (n_err == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
